FILE: sv/idea_pkg.sv
// Shared types, constants and index functions for the IDEA CBC block.
package idea_pkg;

   localparam int SubkeyCount = 52;
   localparam int SubkeyAw    = $clog2(SubkeyCount);
   localparam int CsrIndexW   = 2;

   localparam logic [CsrIndexW-1:0] CSR_KEY_HIGH       = 2'd0;
   localparam logic [CsrIndexW-1:0] CSR_KEY_LOW        = 2'd1;
   localparam logic [CsrIndexW-1:0] CSR_DIRECTION      = 2'd2;
   localparam logic [CsrIndexW-1:0] CSR_INITIAL_VECTOR = 2'd3;

   typedef enum logic [3:0] {
      ST_KEY_LOAD,
      ST_KEY_GEN,
      ST_INV_SQ,
      ST_INV_SQ_CAP,
      ST_INV_MB,
      ST_INV_MB_CAP,
      ST_IDLE,
      ST_RUN,
      ST_FINISH
   } state_type;

   // Six times a small value, built from shifts.
   function automatic logic [SubkeyAw-1:0] times_six(input logic [3:0] r);
      logic [SubkeyAw-1:0] w;
      begin
         w = {{(SubkeyAw-4){1'b0}}, r};
         times_six = (w << 2) + (w << 1);
      end
   endfunction

   // Position of encryption subkey (group q, slot m) in the encryption schedule.
   function automatic logic [SubkeyAw-1:0] enc_dest(input logic [3:0] q, input logic [2:0] m);
      begin
         enc_dest = times_six(q) + {{(SubkeyAw-3){1'b0}}, m};
      end
   endfunction

   // Position that encryption subkey (group q, slot m) takes in the decryption schedule.
   function automatic logic [SubkeyAw-1:0] dec_dest(input logic [3:0] q, input logic [2:0] m);
      logic [3:0] r;
      logic [2:0] slot;
      begin
         r    = 4'd8 - q;
         slot = m;
         case (m)
            3'd0, 3'd3: begin
               slot = m;
            end
            3'd1, 3'd2: begin
               // The two additive keys swap places except in the outer rounds.
               if (r == 4'd0 || r == 4'd8) begin
                  slot = m;
               end else begin
                  slot = 3'd3 - m;
               end
            end
            3'd4, 3'd5: begin
               r    = 4'd7 - q;
               slot = m;
            end
            default: begin
               slot = m;
            end
         endcase
         dec_dest = times_six(r) + {{(SubkeyAw-3){1'b0}}, slot};
      end
   endfunction

endpackage

FILE: sv/idea_mul.sv
// Multiplier modulo 65537 with a registered product; zero stands for 65536.
module idea_mul (
   input  logic        clock,
   input  logic [15:0] op_a,
   input  logic [15:0] op_b,
   output logic [15:0] result
);
   logic [31:0] prod_ff;
   logic [15:0] a_ff;
   logic [15:0] b_ff;
   logic        za_ff;
   logic        zb_ff;
   logic [16:0] diff;

   always_ff @(posedge clock) begin
      prod_ff <= op_a * op_b;
      a_ff    <= op_a;
      b_ff    <= op_b;
      za_ff   <= (op_a == 16'd0);
      zb_ff   <= (op_b == 16'd0);
   end

   // Since 2^16 is -1 modulo 65537, the high half is subtracted from the low half.
   assign diff = {1'b0, prod_ff[15:0]} - {1'b0, prod_ff[31:16]};

   always_comb begin
      if (za_ff) begin
         result = 16'd1 - b_ff;
      end else if (zb_ff) begin
         result = 16'd1 - a_ff;
      end else begin
         result = diff[15:0] + {15'd0, diff[16]};
      end
   end
endmodule

FILE: sv/idea_block_cipher_cbc_top.sv
// IDEA block cipher top level with CBC chaining and subkey derivation.
//
// One 64-bit block is accepted at a time. A block runs eight rounds and
// an output transform through a single pipelined modulo-65537 multiplier,
// then loads the result register once no earlier result is held stalled;
// the next block is accepted only after that. Writing key_high, key_low
// or direction (and leaving reset) starts a subkey derivation during
// which req_stall stays high. For decryption the 18 multiplicative
// inverses are each raised to the power 65535 with 30 passes through the
// same multiplier. Writing initial_vector only takes effect on a block
// that has req_restart_chain set.
module idea_block_cipher_cbc_top (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_stall,
   input  logic [63:0]                    req_block_in,
   input  logic                           req_restart_chain,
   output logic                           rsp_valid,
   input  logic                           rsp_stall,
   output logic [63:0]                    rsp_block_out,
   input  logic                           csr_write,
   input  logic [idea_pkg::CsrIndexW-1:0] csr_index,
   input  logic [63:0]                    csr_data
);
   import idea_pkg::*;

   state_type state_ff, state_in;

   logic [63:0]  key_high_ff, key_low_ff, iv_ff;
   logic         dir_ff;

   logic [127:0] kr_ff, kr_in;
   logic [2:0]   kc_ff, kc_in;
   logic [3:0]   kq_ff, kq_in;
   logic [2:0]   km_ff, km_in;
   logic [15:0]  acc_ff, acc_in;
   logic [15:0]  ibase_ff, ibase_in;
   logic [3:0]   icnt_ff, icnt_in;

   logic [15:0]  x0_ff, x1_ff, x2_ff, x3_ff;
   logic [15:0]  x0_in, x1_in, x2_in, x3_in;
   logic [15:0]  a_ff, b_ff, c_ff, d_ff, t_ff;
   logic [15:0]  a_in, b_in, c_in, d_in, t_in;
   logic [3:0]   step_ff, step_in;
   logic [3:0]   round_ff, round_in;
   logic [SubkeyAw-1:0] kbase_ff, kbase_in;

   logic [63:0]  chain_ff, chain_in;
   logic [63:0]  blk_ff, blk_in;
   logic         rsp_valid_ff, rsp_valid_in;
   logic [63:0]  rsp_data_ff, rsp_data_in;

   logic [15:0]  subkey_mem [SubkeyCount];
   logic [15:0]  kd_ff;
   logic [SubkeyAw-1:0] kaddr;
   logic         mem_we;
   logic [SubkeyAw-1:0] mem_waddr;
   logic [15:0]  mem_wdata;

   logic [15:0]  mul_a, mul_b, mul_res;

   logic [15:0]  chunk;
   logic         last_key;
   logic         key_restart;
   logic         accept;
   logic         fin;
   logic [15:0]  tu;
   logic [63:0]  cipher_out;
   logic [63:0]  chain_sel;

   idea_mul u_mul (
      .clock  (clock),
      .op_a   (mul_a),
      .op_b   (mul_b),
      .result (mul_res)
   );

   assign accept      = req_valid && !req_stall;
   assign req_stall   = (state_ff != ST_IDLE);
   assign rsp_valid   = rsp_valid_ff;
   assign rsp_block_out = rsp_data_ff;
   assign key_restart = csr_write && (csr_index inside {CSR_KEY_HIGH, CSR_KEY_LOW, CSR_DIRECTION});
   assign chunk       = kr_ff[(7 - kc_ff) * 16 +: 16];
   assign last_key    = (kq_ff == 4'd8) && (km_ff == 3'd3);
   assign fin         = (round_ff == 4'd8);
   assign tu          = t_ff + mul_res;
   assign cipher_out  = {a_ff, b_ff, c_ff, d_ff};
   assign chain_sel   = req_restart_chain ? iv_ff : chain_ff;

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_KEY_LOAD: begin
            state_in = ST_KEY_GEN;
         end
         ST_KEY_GEN: begin
            if (dir_ff && (km_ff == 3'd0 || km_ff == 3'd3)) begin
               state_in = ST_INV_SQ;
            end else if (last_key) begin
               state_in = ST_IDLE;
            end
         end
         ST_INV_SQ: begin
            state_in = ST_INV_SQ_CAP;
         end
         ST_INV_SQ_CAP: begin
            state_in = ST_INV_MB;
         end
         ST_INV_MB: begin
            state_in = ST_INV_MB_CAP;
         end
         ST_INV_MB_CAP: begin
            if (icnt_ff != 4'd0) begin
               state_in = ST_INV_SQ;
            end else if (last_key) begin
               state_in = ST_IDLE;
            end else begin
               state_in = ST_KEY_GEN;
            end
         end
         ST_IDLE: begin
            if (accept) begin
               state_in = ST_RUN;
            end
         end
         ST_RUN: begin
            if (fin && step_ff == 4'd4) begin
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_KEY_LOAD;
         end
      endcase
      if (key_restart) begin
         state_in = ST_KEY_LOAD;
      end
   end

   // Datapath controls and register updates.
   always_comb begin
      logic advance;
      advance    = 1'b0;
      kr_in      = kr_ff;
      kc_in      = kc_ff;
      kq_in      = kq_ff;
      km_in      = km_ff;
      acc_in     = acc_ff;
      ibase_in   = ibase_ff;
      icnt_in    = icnt_ff;
      x0_in      = x0_ff;
      x1_in      = x1_ff;
      x2_in      = x2_ff;
      x3_in      = x3_ff;
      a_in       = a_ff;
      b_in       = b_ff;
      c_in       = c_ff;
      d_in       = d_ff;
      t_in       = t_ff;
      step_in    = step_ff;
      round_in   = round_ff;
      kbase_in   = kbase_ff;
      chain_in   = chain_ff;
      blk_in     = blk_ff;
      rsp_data_in  = rsp_data_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      mem_we     = 1'b0;
      mem_waddr  = enc_dest(kq_ff, km_ff);
      mem_wdata  = chunk;
      mul_a      = 16'd0;
      mul_b      = 16'd0;
      kaddr      = '0;

      case (state_ff)
         ST_KEY_LOAD: begin
            kr_in = {key_high_ff, key_low_ff};
            kc_in = 3'd0;
            kq_in = 4'd0;
            km_in = 3'd0;
         end
         ST_KEY_GEN: begin
            if (!dir_ff) begin
               mem_we  = 1'b1;
               advance = 1'b1;
            end else if (km_ff == 3'd0 || km_ff == 3'd3) begin
               acc_in   = chunk;
               ibase_in = chunk;
               icnt_in  = 4'd14;
            end else begin
               mem_we    = 1'b1;
               mem_waddr = dec_dest(kq_ff, km_ff);
               mem_wdata = (km_ff == 3'd1 || km_ff == 3'd2) ? 16'd0 - chunk : chunk;
               advance   = 1'b1;
            end
         end
         ST_INV_SQ: begin
            mul_a = acc_ff;
            mul_b = acc_ff;
         end
         ST_INV_SQ_CAP: begin
            acc_in = mul_res;
         end
         ST_INV_MB: begin
            mul_a = acc_ff;
            mul_b = ibase_ff;
         end
         ST_INV_MB_CAP: begin
            acc_in = mul_res;
            if (icnt_ff != 4'd0) begin
               icnt_in = icnt_ff - 4'd1;
            end else begin
               mem_we    = 1'b1;
               mem_waddr = dec_dest(kq_ff, km_ff);
               mem_wdata = mul_res;
               advance   = 1'b1;
            end
         end
         ST_IDLE: begin
            if (accept) begin
               chain_in = chain_sel;
               blk_in   = req_block_in;
               {x0_in, x1_in, x2_in, x3_in} = dir_ff ? req_block_in
                                                     : (req_block_in ^ chain_sel);
               step_in  = 4'd1;
               round_in = 4'd0;
               kbase_in = '0;
            end
         end
         ST_RUN: begin
            step_in = step_ff + 4'd1;
            case (step_ff)
               4'd1: begin
                  mul_a = x0_ff;
                  mul_b = kd_ff;
                  kaddr = kbase_ff + SubkeyAw'(3);
               end
               4'd2: begin
                  a_in  = mul_res;
                  mul_a = x3_ff;
                  mul_b = kd_ff;
                  kaddr = kbase_ff + SubkeyAw'(1);
               end
               4'd3: begin
                  d_in  = mul_res;
                  b_in  = (fin ? x2_ff : x1_ff) + kd_ff;
                  kaddr = kbase_ff + SubkeyAw'(2);
               end
               4'd4: begin
                  c_in  = (fin ? x1_ff : x2_ff) + kd_ff;
                  kaddr = fin ? '0 : kbase_ff + SubkeyAw'(4);
               end
               4'd5: begin
                  mul_a = kd_ff;
                  mul_b = a_ff ^ c_ff;
                  kaddr = kbase_ff + SubkeyAw'(5);
               end
               4'd6: begin
                  t_in  = mul_res;
                  kaddr = kbase_ff + SubkeyAw'(5);
               end
               4'd7: begin
                  mul_a = (b_ff ^ d_ff) + t_ff;
                  mul_b = kd_ff;
                  kaddr = kbase_ff + SubkeyAw'(5);
               end
               4'd8: begin
                  // Mixing layer closes the round; the next round's first key is fetched.
                  x0_in    = a_ff ^ mul_res;
                  x1_in    = c_ff ^ mul_res;
                  x2_in    = b_ff ^ tu;
                  x3_in    = d_ff ^ tu;
                  round_in = round_ff + 4'd1;
                  kbase_in = kbase_ff + SubkeyAw'(6);
                  kaddr    = kbase_ff + SubkeyAw'(6);
                  step_in  = 4'd1;
               end
               default: begin
                  step_in = 4'd1;
               end
            endcase
         end
         ST_FINISH: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = dir_ff ? (cipher_out ^ chain_ff) : cipher_out;
               chain_in     = dir_ff ? blk_ff : cipher_out;
            end
         end
         default: begin
            kaddr = '0;
         end
      endcase

      if (advance) begin
         if (kc_ff == 3'd7) begin
            kr_in = {kr_ff[102:0], kr_ff[127:103]};
         end
         kc_in = kc_ff + 3'd1;
         if (km_ff == 3'd5) begin
            km_in = 3'd0;
            kq_in = kq_ff + 4'd1;
         end else begin
            km_in = km_ff + 3'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_KEY_LOAD;
         key_high_ff  <= '0;
         key_low_ff   <= '0;
         dir_ff       <= 1'b0;
         iv_ff        <= '0;
         chain_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         chain_ff     <= chain_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_write) begin
            case (csr_index)
               CSR_KEY_HIGH:       key_high_ff <= csr_data;
               CSR_KEY_LOW:        key_low_ff  <= csr_data;
               CSR_DIRECTION:      dir_ff      <= csr_data[0];
               CSR_INITIAL_VECTOR: iv_ff       <= csr_data;
               default:            iv_ff       <= iv_ff;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      kr_ff       <= kr_in;
      kc_ff       <= kc_in;
      kq_ff       <= kq_in;
      km_ff       <= km_in;
      acc_ff      <= acc_in;
      ibase_ff    <= ibase_in;
      icnt_ff     <= icnt_in;
      x0_ff       <= x0_in;
      x1_ff       <= x1_in;
      x2_ff       <= x2_in;
      x3_ff       <= x3_in;
      a_ff        <= a_in;
      b_ff        <= b_in;
      c_ff        <= c_in;
      d_ff        <= d_in;
      t_ff        <= t_in;
      step_ff     <= step_in;
      round_ff    <= round_in;
      kbase_ff    <= kbase_in;
      blk_ff      <= blk_in;
      rsp_data_ff <= rsp_data_in;
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         subkey_mem[mem_waddr] <= mem_wdata;
      end
      kd_ff <= subkey_mem[kaddr];
   end

`ifndef SYNTHESIS
   a_key_write_stalls: assert property (@(posedge clock) disable iff (reset)
      (csr_write && (csr_index == CSR_KEY_HIGH || csr_index == CSR_KEY_LOW ||
                     csr_index == CSR_DIRECTION)) |=> req_stall)
      else $error("input not stalled during subkey derivation");

   a_accept_then_busy: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> (req_stall && state_ff == ST_RUN))
      else $error("block not started after accept");

   a_result_from_finish: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(state_ff == ST_FINISH))
      else $error("result raised outside finish");

   a_round_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_RUN) |-> (round_ff <= 4'd8 && step_ff != 4'd0))
      else $error("round sequencer out of range");
`endif
endmodule
